/* hdl/hosp_pkg.sv */
// shared types, constants and character helpers for the hex octet string parser
package hosp_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 9;

  // build-time ceiling on octets per string, applied over max_bytes
  localparam int unsigned MAX_OCTETS = 256;
  localparam int unsigned LIM_W      = 17;
  localparam logic [LIM_W-1:0] MAX_OCTETS_L = LIM_W'(MAX_OCTETS);

  localparam logic [CNT_W-1:0] MAX_BYTES_RST = CNT_W'(256);
  localparam logic [CH_W-1:0]  SEP_RST       = CH_W'(58);
  localparam logic [CH_W-1:0]  CH_NUL        = '0;

  typedef logic [CH_W-1:0]      ch_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [7:0]           octet_t;
  typedef logic [3:0]           nibble_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_BYTES = 1'd0,
    REG_SEPARATOR = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_NEXT      = 3'd1,
    PH_AFTER_SEP = 3'd2,
    PH_LOW       = 3'd3,
    PH_TRAIL     = 3'd4,
    PH_DROP      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_HIGH  = 3'd1,
    ERR_NO_LOW    = 3'd2,
    ERR_BAD_LOW   = 3'd3,
    ERR_TOO_MANY  = 3'd4
  } err_t;

  function automatic logic is_space(input ch_t c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input ch_t c);
    logic [4:0] v;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = 5'(c - 8'd48);
    end else if (c >= 8'd97 && c <= 8'd102) begin
      v = 5'(c - 8'd87);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = 5'(c - 8'd55);
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

/* hdl/hosp_char_if.sv */
// character input channel
interface hosp_char_if;
  logic           valid;
  logic           ready;
  hosp_pkg::ch_t  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* hdl/hosp_result_if.sv */
// result channel: octet, done or error
interface hosp_result_if;
  logic             valid;
  logic             ready;
  hosp_pkg::kind_t  kind;
  hosp_pkg::octet_t byte_value;
  hosp_pkg::cnt_t   byte_count;
  hosp_pkg::err_t   error_code;

  modport source (output valid, output kind, output byte_value, output byte_count,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input byte_value, input byte_count,
                  input error_code, output ready);
endinterface

/* hdl/hosp_cfg_if.sv */
// configuration write channel
interface hosp_cfg_if;
  logic                valid;
  logic                ready;
  hosp_pkg::cfg_idx_t  index;
  hosp_pkg::cfg_dat_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/hex_octet_string_parser.sv */
// hex octet string parser: character register, decode step, result register
// res.valid is driven from the result register, which is loaded from the character register
// throughput: one character per cycle while the result side keeps taking
// the decode step and the phase/count update sit between the two registers
// rst (synchronous) returns to the leading whitespace phase with count 0,
// max_bytes 256 and separator ':'; both pipeline registers are emptied
module hex_octet_string_parser (
  input  logic clk,
  input  logic rst,
  hosp_char_if.sink    chr,
  hosp_cfg_if.sink     cfg,
  hosp_result_if.source res
);
  import hosp_pkg::*;

  // configuration registers
  cnt_t max_bytes;
  ch_t  separator_char;

  // character register
  logic s1_valid;
  ch_t  s1_ch;
  logic s1_adv;

  // decode state
  phase_t  phase, phase_next;
  nibble_t high_nibble, high_nibble_next;
  cnt_t    count, count_next;

  // result register
  logic   out_valid;
  kind_t  out_kind;
  octet_t out_val;
  cnt_t   out_count;
  err_t   out_err;

  // decode outputs
  logic   r_emit;
  kind_t  r_kind;
  octet_t r_val;
  cnt_t   r_count;
  err_t   r_err;

  logic [4:0]       dig;
  logic             sp;
  logic [LIM_W-1:0] limit;
  logic             at_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes      <= MAX_BYTES_RST;
      separator_char <= SEP_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_BYTES: max_bytes      <= cfg.data;
        REG_SEPARATOR: separator_char <= cfg.data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // the character stage moves on when the result register is free or being emptied
  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign chr.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chr.ready) begin
      s1_valid <= chr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chr.valid && chr.ready) begin
      s1_ch <= chr.ch;
    end
  end

  assign dig      = hex_value(s1_ch);
  assign sp       = is_space(s1_ch);
  assign limit    = ({8'b0, max_bytes} > MAX_OCTETS_L) ? MAX_OCTETS_L : {8'b0, max_bytes};
  assign at_limit = {8'b0, count} >= limit;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    count_next       = count;
    r_emit           = 1'b0;
    r_kind           = KIND_DONE;
    r_val            = '0;
    r_count          = count;
    r_err            = ERR_NONE;
    unique case (phase)
      PH_LEAD, PH_NEXT, PH_TRAIL: begin
        if (s1_ch == CH_NUL) begin
          r_emit = 1'b1;
          r_kind = KIND_DONE;
          phase_next       = PH_LEAD;
          high_nibble_next = '0;
          count_next       = '0;
        end else if (phase == PH_LEAD && sp) begin
          phase_next = PH_LEAD;
        end else if (phase == PH_TRAIL || at_limit) begin
          // only whitespace or the terminator may follow once the limit is reached
          phase_next = PH_TRAIL;
          if (!sp) begin
            r_emit     = 1'b1;
            r_kind     = KIND_ERR;
            r_err      = ERR_TOO_MANY;
            phase_next = PH_DROP;
          end
        end else if (phase == PH_NEXT && s1_ch == separator_char) begin
          phase_next = PH_AFTER_SEP;
        end else if (dig[4]) begin
          r_emit     = 1'b1;
          r_kind     = KIND_ERR;
          r_err      = ERR_BAD_HIGH;
          phase_next = PH_DROP;
        end else begin
          high_nibble_next = dig[3:0];
          phase_next       = PH_LOW;
        end
      end
      PH_AFTER_SEP: begin
        if (dig[4]) begin
          r_emit = 1'b1;
          r_kind = KIND_ERR;
          r_err  = ERR_BAD_HIGH;
          if (s1_ch == CH_NUL) begin
            phase_next       = PH_LEAD;
            high_nibble_next = '0;
            count_next       = '0;
          end else begin
            phase_next = PH_DROP;
          end
        end else begin
          high_nibble_next = dig[3:0];
          phase_next       = PH_LOW;
        end
      end
      PH_LOW: begin
        if (s1_ch == CH_NUL) begin
          r_emit           = 1'b1;
          r_kind           = KIND_ERR;
          r_err            = ERR_NO_LOW;
          phase_next       = PH_LEAD;
          high_nibble_next = '0;
          count_next       = '0;
        end else if (dig[4]) begin
          r_emit     = 1'b1;
          r_kind     = KIND_ERR;
          r_err      = ERR_BAD_LOW;
          phase_next = PH_DROP;
        end else begin
          r_emit           = 1'b1;
          r_kind           = KIND_BYTE;
          r_val            = {high_nibble, dig[3:0]};
          count_next       = count + 1'b1;
          r_count          = count + 1'b1;
          high_nibble_next = '0;
          phase_next       = PH_NEXT;
        end
      end
      default: begin
        // dropping after an error, the terminator ends the string silently
        if (s1_ch == CH_NUL) begin
          phase_next       = PH_LEAD;
          high_nibble_next = '0;
          count_next       = '0;
        end else begin
          phase_next = PH_DROP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      high_nibble <= '0;
      count       <= '0;
    end else if (s1_adv) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      count       <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= r_emit;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && r_emit) begin
      out_kind  <= r_kind;
      out_val   <= r_val;
      out_count <= r_count;
      out_err   <= r_err;
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.byte_value = out_val;
  assign res.byte_count = out_count;
  assign res.error_code = out_err;

  // an octet result always carries a nonzero count and no error
  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_BYTE |-> out_err == ERR_NONE && out_count != '0)
    else $error("octet result with error code or zero count");

  // error code is set exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == KIND_ERR) == (out_err != ERR_NONE)))
    else $error("error code does not match result kind");

  // leading phase always starts from a clean count and nibble
  a_lead_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEAD |-> count == '0 && high_nibble == '0)
    else $error("leading phase with stale count or nibble");

  // a terminator always ends the string
  a_nul_ends: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_ch == CH_NUL |=> phase == PH_LEAD)
    else $error("terminator did not end the string");

endmodule

/* dv/tb_top.sv */
// testbench for the hex octet string parser: directed and random character streams
module tb_top;
  import hosp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_CHARS = 500;

  typedef struct packed {
    kind_t  kind;
    octet_t value;
    cnt_t   count;
    err_t   error;
  } parse_result_t;

  logic clk;
  logic rst;

  hosp_char_if   chr ();
  hosp_cfg_if    cfg ();
  hosp_result_if res ();

  hex_octet_string_parser u_dut (
    .clk(clk),
    .rst(rst),
    .chr(chr),
    .cfg(cfg),
    .res(res)
  );

  // parser state as the testbench sees it, plus register copies
  phase_t  ph            = PH_LEAD;
  nibble_t high_nib      = '0;
  cnt_t    octets        = '0;
  cnt_t    max_bytes_cfg = MAX_BYTES_RST;
  ch_t     sep_cfg       = SEP_RST;

  parse_result_t pending_results[$];
  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int stall_run   = 0;
  int chars_sent  = 0;

  always #5 clk = ~clk;

  function automatic logic is_blank(input ch_t c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // bit 4 flags a character that is not a hex digit
  function automatic logic [4:0] digit_of(input ch_t c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'h10;
  endfunction

  function automatic void restart();
    ph       = PH_LEAD;
    high_nib = '0;
    octets   = '0;
  endfunction

  function automatic void raise_error(input err_t code, input ch_t c);
    pending_results.push_back('{KIND_ERR, 8'h00, octets, code});
    if (c == CH_NUL) restart();
    else ph = PH_DROP;
  endfunction

  function automatic void parse_char(input ch_t c);
    cnt_t       lim;
    logic [4:0] d;
    logic       want_high;
    logic       at_limit;
    logic       finish;
    lim       = (max_bytes_cfg > 9'd256) ? 9'd256 : max_bytes_cfg;
    d         = digit_of(c);
    want_high = 1'b0;
    at_limit  = 1'b0;
    finish    = 1'b0;
    case (ph)
      PH_LEAD: begin
        if (c == CH_NUL) finish = 1'b1;
        else if (!is_blank(c)) begin
          if (octets >= lim) at_limit = 1'b1;
          else want_high = 1'b1;
        end
      end
      PH_NEXT: begin
        // terminator wins over a separator of code 0
        if (c == CH_NUL) finish = 1'b1;
        else if (octets >= lim) at_limit = 1'b1;
        else if (c == sep_cfg) ph = PH_AFTER_SEP;
        else want_high = 1'b1;
      end
      PH_AFTER_SEP: want_high = 1'b1;
      PH_LOW: begin
        if (c == CH_NUL) raise_error(ERR_NO_LOW, c);
        else if (d[4]) raise_error(ERR_BAD_LOW, c);
        else begin
          octets = octets + 9'd1;
          pending_results.push_back('{KIND_BYTE, {high_nib, d[3:0]}, octets, ERR_NONE});
          high_nib = '0;
          ph       = PH_NEXT;
        end
      end
      PH_TRAIL: begin
        if (c == CH_NUL) finish = 1'b1;
        else at_limit = 1'b1;
      end
      default: begin
        // swallowing input after an error, terminator ends silently
        if (c == CH_NUL) restart();
        else ph = PH_DROP;
      end
    endcase
    if (want_high) begin
      if (d[4]) raise_error(ERR_BAD_HIGH, c);
      else begin
        high_nib = d[3:0];
        ph       = PH_LOW;
      end
    end
    if (at_limit) begin
      ph = PH_TRAIL;
      if (!is_blank(c)) raise_error(ERR_TOO_MANY, c);
    end
    if (finish) begin
      pending_results.push_back('{KIND_DONE, 8'h00, octets, ERR_NONE});
      restart();
    end
  endfunction

  function automatic ch_t hex_char(input nibble_t n);
    if (n < 4'd10) return ch_t'("0" + n);
    if ($urandom_range(0, 1) != 0) return ch_t'("a" + n - 8'd10);
    return ch_t'("A" + n - 8'd10);
  endfunction

  function automatic ch_t blank_char();
    int k;
    k = $urandom_range(9, 14);
    return (k == 14) ? 8'd32 : ch_t'(k);
  endfunction

  // sender works in bursts, with gaps of random length between them
  task automatic send_char(input ch_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        chr.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 12);
    end
    burst_left--;
    chr.valid <= 1'b1;
    chr.ch    <= c;
    @(posedge clk);
    while (!chr.ready) @(posedge clk);
    chars_sent++;
    parse_char(c);
  endtask

  task automatic send_string(input ch_t s[$]);
    foreach (s[i]) send_char(s[i]);
  endtask

  // block quiet: every expected result back, then time for the pipe to empty
  task automatic drain();
    chr.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input cfg_dat_t value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_MAX_BYTES) max_bytes_cfg = value;
    else sep_cfg = value[7:0];
  endtask

  task automatic set_config(input cfg_dat_t max_val, input cfg_dat_t sep_val);
    cfg_write(REG_MAX_BYTES, max_val);
    cfg_write(REG_SEPARATOR, sep_val);
  endtask

  task automatic send_random_string();
    ch_t     s[$];
    int      lim;
    int      n;
    int      style;
    int      i;
    octet_t  v;
    lim   = (max_bytes_cfg > 9'd256) ? 256 : int'(max_bytes_cfg);
    style = $urandom_range(0, 19);
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) s.push_back(ch_t'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) s.push_back(blank_char());
      n = $urandom_range(0, (lim < 6) ? lim : 6);
      if (style == 1 && lim <= 8) n = lim + 1;
      for (i = 0; i < n; i++) begin
        if (i != 0 && sep_cfg != CH_NUL && $urandom_range(0, 1) != 0) s.push_back(sep_cfg);
        v = 8'($urandom_range(0, 255));
        s.push_back(hex_char(v[7:4]));
        s.push_back(hex_char(v[3:0]));
      end
      if (n >= lim) repeat ($urandom_range(0, 2)) s.push_back(blank_char());
      if (style == 2 && s.size() != 0) s[$urandom_range(0, s.size() - 1)] = ch_t'($urandom_range(0, 255));
      if (style == 3 && s.size() != 0) void'(s.pop_back());
    end
    // an open string carries over, so a later write lands part way through it
    if (style != 4) s.push_back(CH_NUL);
    send_string(s);
  endtask

  task automatic test_basic_decode();
    send_string('{8'd13, "F", "f", ":", "0", "9", CH_NUL});
  endtask

  task automatic test_format_errors();
    send_string('{"1", "2", " ", 8'hFF, CH_NUL});
    send_string('{"5", CH_NUL});
    send_string('{"a", "Z", CH_NUL});
    send_string('{"1", "2", ":", CH_NUL});
  endtask

  task automatic test_separator_rules();
    set_config(9'd2, 9'h000);
    send_string('{"0", "0", CH_NUL});
    set_config(9'd511, 9'(8'("b")));
    send_string('{"b", "1", "b", "c", "2", CH_NUL});
  endtask

  task automatic test_octet_limit();
    set_config(9'd0, 9'(8'(":")));
    send_string('{" ", "a", CH_NUL});
    set_config(9'd1, 9'(8'(":")));
    send_string('{"E", "e", 8'd9, ":", CH_NUL});
  endtask

  task automatic test_full_length();
    octet_t v;
    set_config(9'd256, 9'h1FF);
    repeat (256) begin
      v = 8'($urandom_range(0, 255));
      send_char(hex_char(v[7:4]));
      send_char(hex_char(v[3:0]));
    end
    send_string('{"0", "0", CH_NUL});
  endtask

  task automatic test_random_streams();
    int       first;
    int       strings;
    cfg_dat_t next_max;
    ch_t      next_sep;
    first   = chars_sent;
    strings = 0;
    while (chars_sent - first < RANDOM_CHARS) begin
      if (strings % 6 == 0) begin
        case ($urandom_range(0, 6))
          0: next_max = 9'd0;
          1: next_max = 9'd1;
          2: next_max = 9'd256;
          3: next_max = 9'd511;
          4: next_max = 9'($urandom_range(0, 511));
          default: next_max = 9'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 6))
          0: next_sep = ":";
          1: next_sep = " ";
          2: next_sep = CH_NUL;
          3: next_sep = 8'hFF;
          4: next_sep = hex_char(4'($urandom_range(0, 15)));
          5: next_sep = "-";
          default: next_sep = ch_t'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0: cfg_write(REG_MAX_BYTES, next_max);
          1: cfg_write(REG_SEPARATOR, {1'($urandom_range(0, 1)), next_sep});
          default: set_config(next_max, {1'($urandom_range(0, 1)), next_sep});
        endcase
      end
      send_random_string();
      strings++;
    end
  endtask

  // receiver stalls on its own pattern, picking a new one when its run counter expires
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= ($urandom_range(0, 3) != 0);
      2: res.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          res.ready <= ~res.ready;
          stall_run <= $urandom_range(1, 10);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t got;
    if (!rst && res.valid && res.ready) begin
      got = '{res.kind, res.byte_value, res.byte_count, res.error_code};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %02h count %0d error %0d",
                   got.kind, got.value, got.count, got.error);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.count !== want.count || got.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d value %02h/%02h count %0d/%0d error %0d/%0d",
                     want.kind, got.kind, want.value, got.value,
                     want.count, got.count, want.error, got.error);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (chr.valid && chr.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    chr.valid = 1'b0;
    chr.ch    = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    res.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_decode();
    test_format_errors();
    test_separator_rules();
    test_octet_limit();
    test_full_length();
    test_random_streams();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/hosp_pkg.sv
hdl/hosp_char_if.sv
hdl/hosp_result_if.sv
hdl/hosp_cfg_if.sv
hdl/hex_octet_string_parser.sv
dv/tb_top.sv
